[rtl/nmf_pkg.sv]
package nmf_pkg;

  // Fixed field widths of the stream beats
  localparam int SAMPLE_W   = 16;
  localparam int IN_TAPS    = 9;
  localparam int MASK_LSB   = SAMPLE_W * IN_TAPS;
  localparam int IN_DATA_W  = 160;
  localparam int MED_W      = 17;
  localparam int OUT_DATA_W = 24;

  // Configuration port
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;
  localparam int CNT_W      = 4;

  localparam logic [1:0] REG_WINDOW_COUNT = 2'd0;

  // Parameter defaults
  localparam int DEF_WINDOW_TAPS = 9;
  localparam int DEF_SAMPLE_BITS = 16;

  // Sample count / rank within the window
  typedef logic [CNT_W-1:0] cnt_t;

  localparam cnt_t WINDOW_COUNT_RST = cnt_t'(9);

endpackage

[rtl/nmf_lane.sv]
module nmf_lane #(
  parameter int WINDOW_TAPS = 9,
  parameter int SAMPLE_BITS = 16,
  parameter int LANE        = 0
) (
  input  logic [WINDOW_TAPS*SAMPLE_BITS-1:0] vals,
  input  logic [WINDOW_TAPS-1:0]             active,
  output nmf_pkg::cnt_t                      rank
);
  import nmf_pkg::*;

  logic [SAMPLE_BITS-1:0] own;
  logic [SAMPLE_BITS-1:0] other;
  cnt_t                   acc;

  // Rank = number of active samples ordered before this one; ties go by position
  always_comb begin
    own = vals[LANE*SAMPLE_BITS +: SAMPLE_BITS];
    acc = '0;
    for (int j = 0; j < WINDOW_TAPS; j++) begin
      other = vals[j*SAMPLE_BITS +: SAMPLE_BITS];
      if (j != LANE && active[j] && ((other < own) || (other == own && j < LANE))) begin
        acc = acc + cnt_t'(1);
      end
    end
    rank = acc;
  end

endmodule

[rtl/nmf_merge.sv]
module nmf_merge #(
  parameter int WINDOW_TAPS = 9,
  parameter int SAMPLE_BITS = 16
) (
  input  logic [WINDOW_TAPS*SAMPLE_BITS-1:0]   vals,
  input  logic [WINDOW_TAPS*nmf_pkg::CNT_W-1:0] ranks,
  input  logic [WINDOW_TAPS-1:0]               active,
  input  nmf_pkg::cnt_t                        count,
  output logic [nmf_pkg::MED_W-1:0]            median
);
  import nmf_pkg::*;

  cnt_t                   half;
  cnt_t                   lo_rank;
  logic [SAMPLE_BITS-1:0] hi_v;
  logic [SAMPLE_BITS-1:0] lo_v;

  // Ranks are unique among active lanes, so an OR of the matches selects one
  always_comb begin
    half    = count >> 1;
    lo_rank = half - cnt_t'(1);
    hi_v    = '0;
    lo_v    = '0;
    for (int i = 0; i < WINDOW_TAPS; i++) begin
      if (active[i] && ranks[i*CNT_W +: CNT_W] == half) begin
        hi_v = hi_v | vals[i*SAMPLE_BITS +: SAMPLE_BITS];
      end
      if (active[i] && ranks[i*CNT_W +: CNT_W] == lo_rank) begin
        lo_v = lo_v | vals[i*SAMPLE_BITS +: SAMPLE_BITS];
      end
    end
    if (count[0]) begin
      median = MED_W'({hi_v, 1'b0});
    end else begin
      median = MED_W'(hi_v) + MED_W'(lo_v);
    end
  end

endmodule

[rtl/neighbourhood_median_filter_top.sv]
// Neighbourhood median filter, 3x3 style.
//
// Input stream (s_t*): one beat carries nine 16-bit samples and a 9-bit
// validity mask. A sample whose mask bit is clear counts as zero. Only the
// first window_count samples (clamped to 1..WINDOW_TAPS) take part.
// Output stream (m_t*): one beat per input beat, the median times two
// (17 bits, one fractional bit; even counts give the exact half average).
//
// Config: APB register 0 (byte address 0) = window_count[3:0], reset 9.
// Change it only while the pipeline is empty.
//
// Timing: one beat per clock sustained. Stage 1 is a rank lane per sample
// (compare against all others plus a popcount) into the stage 1 register;
// stage 2 selects the middle ranks and adds them into the output register.
// All stages advance together; when the receiver stalls with a beat held
// in the output register, s_tready drops and the whole pipeline holds.
// Reset (rst, synchronous) empties the pipeline and restores window_count.
module neighbourhood_median_filter_top #(
  parameter int WINDOW_TAPS = nmf_pkg::DEF_WINDOW_TAPS,
  parameter int SAMPLE_BITS = nmf_pkg::DEF_SAMPLE_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  // APB config port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [nmf_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [nmf_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [nmf_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready,
  // input stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // s_tdata: sample_0[15:0], sample_1 .. sample_8 (16 bits each),
  // valid_mask[152:144], zero pad[159:153]
  input  logic [nmf_pkg::IN_DATA_W-1:0]     s_tdata,
  // output stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // m_tdata: median_half_units[16:0], zero pad[23:17]
  output logic [nmf_pkg::OUT_DATA_W-1:0]    m_tdata
);
  import nmf_pkg::*;

  cnt_t window_count;
  cnt_t count_eff;

  logic                                 adv;
  logic [WINDOW_TAPS*SAMPLE_BITS-1:0]   in_vals;
  logic [WINDOW_TAPS-1:0]               in_active;
  logic [WINDOW_TAPS*CNT_W-1:0]         in_ranks;

  // stage 1 registers
  logic                                 p1_valid;
  logic [WINDOW_TAPS*SAMPLE_BITS-1:0]   p1_vals;
  logic [WINDOW_TAPS-1:0]               p1_active;
  logic [WINDOW_TAPS*CNT_W-1:0]         p1_ranks;
  cnt_t                                 p1_count;

  logic [MED_W-1:0]                     med_next;
  logic [MED_W-1:0]                     med;

  // ---------------- config register ----------------
  assign pready = 1'b1;
  assign prdata = APB_DATA_W'(window_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      window_count <= WINDOW_COUNT_RST;
    end else if (psel && penable && pwrite && pready &&
                 paddr[APB_ADDR_W-1:2] == REG_WINDOW_COUNT) begin
      window_count <= pwdata[CNT_W-1:0];
    end
  end

  // clamp to 1..WINDOW_TAPS
  always_comb begin
    if (window_count == '0) begin
      count_eff = cnt_t'(1);
    end else if (window_count > cnt_t'(WINDOW_TAPS)) begin
      count_eff = cnt_t'(WINDOW_TAPS);
    end else begin
      count_eff = window_count;
    end
  end

  // ---------------- flow control ----------------
  // Whole pipeline moves unless a finished beat is stuck at the output
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  // ---------------- rank lanes ----------------
  for (genvar i = 0; i < WINDOW_TAPS; i++) begin : g_lane
    // masked-out neighbours read as zero; high sample bits dropped
    assign in_vals[i*SAMPLE_BITS +: SAMPLE_BITS] =
      s_tdata[MASK_LSB + i] ? s_tdata[i*SAMPLE_W +: SAMPLE_BITS] : '0;
    assign in_active[i] = cnt_t'(i) < count_eff;

    nmf_lane #(
      .WINDOW_TAPS (WINDOW_TAPS),
      .SAMPLE_BITS (SAMPLE_BITS),
      .LANE        (i)
    ) u_lane (
      .vals   (in_vals),
      .active (in_active),
      .rank   (in_ranks[i*CNT_W +: CNT_W])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (adv) begin
      p1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_vals   <= in_vals;
      p1_active <= in_active;
      p1_ranks  <= in_ranks;
      p1_count  <= count_eff;
    end
  end

  // ---------------- merge: pick middle rank(s) ----------------
  nmf_merge #(
    .WINDOW_TAPS (WINDOW_TAPS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_merge (
    .vals   (p1_vals),
    .ranks  (p1_ranks),
    .active (p1_active),
    .count  (p1_count),
    .median (med_next)
  );

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      med <= med_next;
    end
  end

  assign m_tdata = OUT_DATA_W'(med);

endmodule
